[hw/rtl/pig_pkg.sv]
// pig_pkg: constants and digit codes for the prime implicant generator
// depends on nothing; imported by prime_implicant_generator and tb_top
package pig_pkg;

	// default number of variables the storage is built for
	localparam int VARS_DEFAULT = 4;

	// most implicants returned for one answer
	localparam int MAX_RESULTS = 32;

	// fixed widths of the item fields
	localparam int MINTERM_W = 4;
	localparam int PI_W      = 4;
	localparam int CFG_W     = 3;

	localparam logic [CFG_W-1:0] NUM_VARS_RESET = 3'd4;

	// ternary cube digit codes, dash sorts below 0 below 1
	typedef logic [1:0] digit_t;
	localparam digit_t DIG_DASH = 2'd0;
	localparam digit_t DIG_ZERO = 2'd1;
	localparam digit_t DIG_ONE  = 2'd2;

endpackage

[hw/rtl/prime_implicant_generator.sv]
// prime_implicant_generator: prime implicant search over a stream of minterms
// depends on pig_pkg for digit codes and field widths
//
// a non-final item is taken while busy is low and busy stays low
// a final item starts a scan of the 3^n cubes, ascending; a cube goes through the shared cover tester,
// and if it is an implicant, so does each parent in turn until one parent is found to be an implicant
// a prime is held until the next prime is found and leaves the cycle after that
// the scan ends in the flush state, at the last cube or at the 32nd prime, and the last prime
// leaves the cycle after it
// the receiver cannot stall; reset clears the minterm bitmap and sets num_vars to 4
module prime_implicant_generator
	import pig_pkg::*;
#(
	parameter int VARS = VARS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// item channel
	input  logic                 start,
	output logic                 busy,
	input  logic [MINTERM_W-1:0] minterm,
	input  logic                 final_term,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data,
	// result channel
	output logic                 pi_valid,
	output logic [PI_W-1:0]      pi_value,
	output logic [PI_W-1:0]      pi_dash_mask,
	output logic                 pi_last
);

	localparam int NV_W     = $clog2(VARS + 1);
	localparam int MT_DEPTH = 1 << VARS;
	localparam int WIDE_W   = (VARS > PI_W) ? VARS : PI_W;
	localparam int CNT_W    = $clog2(MAX_RESULTS + 1);

	// sequencer codes
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]             state_q;
	logic [CFG_W-1:0]       num_vars_q;
	logic [MT_DEPTH-1:0]    bitmap_q;
	digit_t                 cube_q [VARS];
	logic [NV_W-1:0]        step_q;
	logic [CNT_W-1:0]       count_q;
	logic                   pend_valid_q;
	logic [VARS-1:0]        pend_value_q;
	logic [VARS-1:0]        pend_dash_q;
	logic                   pi_valid_q;
	logic [PI_W-1:0]        pi_value_q;
	logic [PI_W-1:0]        pi_dash_mask_q;
	logic                   pi_last_q;

	logic [NV_W-1:0]        nv;
	logic [VARS-1:0]        nv_mask;
	logic [MINTERM_W-1:0]   in_mask;
	logic [WIDE_W-1:0]      in_wide;
	logic [VARS-1:0]        wr_idx;
	logic                   accept;

	digit_t                 cand [VARS];
	logic [VARS-1:0]        cand_val;
	logic [VARS-1:0]        cand_dash;
	logic [VARS-1:0]        cube_val;
	logic [VARS-1:0]        cube_dash;
	logic                   hit;
	logic                   par_fixed;
	logic                   cube_is_last;
	digit_t                 cube_next [VARS];
	logic                   carry;
	logic [VARS-1:0]        mt_v;

	logic                   emit;
	logic [VARS-1:0]        emit_value;
	logic [VARS-1:0]        emit_dash;
	logic                   emit_last;
	logic [WIDE_W-1:0]      emit_value_w;
	logic [WIDE_W-1:0]      emit_dash_w;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = ~busy;
	assign accept    = start & ~busy;

	assign pi_valid     = pi_valid_q;
	assign pi_value     = pi_value_q;
	assign pi_dash_mask = pi_dash_mask_q;
	assign pi_last      = pi_last_q;

	// variable count in use, zero acts as one and large values saturate
	always_comb begin
		if (num_vars_q == '0) begin
			nv = NV_W'(1);
		end else if (int'(num_vars_q) > VARS) begin
			nv = NV_W'(VARS);
		end else begin
			nv = NV_W'(num_vars_q);
		end
		for (int b = 0; b < VARS; b++) begin
			nv_mask[b] = (b < int'(nv));
		end
		for (int i = 0; i < MINTERM_W; i++) begin
			in_mask[i] = (i < int'(nv));
		end
	end

	// masked minterm index into the bitmap
	assign in_wide = WIDE_W'(minterm & in_mask);
	assign wr_idx  = in_wide[VARS-1:0];

	// candidate cube: the scanned cube itself, or its parent with one digit dashed
	always_comb begin
		par_fixed = 1'b0;
		for (int b = 0; b < VARS; b++) begin
			if (step_q != '0 && b + 1 == int'(step_q)) begin
				cand[b]   = DIG_DASH;
				par_fixed = (cube_q[b] != DIG_DASH);
			end else begin
				cand[b] = cube_q[b];
			end
			cand_val[b]  = nv_mask[b] & (cand[b] == DIG_ONE);
			cand_dash[b] = nv_mask[b] & (cand[b] == DIG_DASH);
			cube_val[b]  = nv_mask[b] & (cube_q[b] == DIG_ONE);
			cube_dash[b] = nv_mask[b] & (cube_q[b] == DIG_DASH);
		end
	end

	// shared cover tester: the candidate is an implicant when every minterm it covers is present
	always_comb begin
		hit  = 1'b1;
		mt_v = '0;
		for (int m = 0; m < MT_DEPTH; m++) begin
			mt_v = VARS'(m);
			if ((((mt_v ^ cand_val) & ~cand_dash & nv_mask) == '0)
				&& ((mt_v & ~nv_mask) == '0) && !bitmap_q[m]) begin
				hit = 1'b0;
			end
		end
	end

	// ternary increment over the digits in use, ascending string order
	always_comb begin
		carry        = 1'b1;
		cube_is_last = 1'b1;
		for (int b = 0; b < VARS; b++) begin
			cube_next[b] = cube_q[b];
			if (nv_mask[b]) begin
				if (cube_q[b] != DIG_ONE) begin
					cube_is_last = 1'b0;
				end
				if (carry) begin
					if (cube_q[b] == DIG_ONE) begin
						cube_next[b] = DIG_DASH;
					end else begin
						cube_next[b] = digit_t'(cube_q[b] + 2'd1);
						carry        = 1'b0;
					end
				end
			end
		end
	end

	// a result leaves whenever a newer prime replaces the held one, or at the flush
	always_comb begin
		emit       = 1'b0;
		emit_last  = 1'b0;
		emit_value = pend_value_q;
		emit_dash  = pend_dash_q;
		if (state_q == ST_FLUSH) begin
			emit      = pend_valid_q;
			emit_last = 1'b1;
		end else if (state_q == ST_SCAN && step_q != '0 && !(hit && par_fixed)
			&& step_q == nv) begin
			emit = pend_valid_q;
		end
	end

	assign emit_value_w = WIDE_W'(emit_value);
	assign emit_dash_w  = WIDE_W'(emit_dash);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			num_vars_q   <= NUM_VARS_RESET;
			bitmap_q     <= '0;
			step_q       <= '0;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			pi_valid_q   <= 1'b0;
			for (int b = 0; b < VARS; b++) begin
				cube_q[b] <= DIG_DASH;
			end
		end else begin
			pi_valid_q <= emit;
			if (cfg_valid && cfg_ready) begin
				num_vars_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bitmap_q[wr_idx] <= 1'b1;
						if (final_term) begin
							state_q      <= ST_SCAN;
							step_q       <= '0;
							count_q      <= '0;
							pend_valid_q <= 1'b0;
							for (int b = 0; b < VARS; b++) begin
								cube_q[b] <= DIG_DASH;
							end
						end
					end
				end
				ST_SCAN: begin
					if (step_q == '0) begin
						// the cube itself: not an implicant means move on
						if (hit) begin
							step_q <= NV_W'(1);
						end else begin
							if (cube_is_last) begin
								state_q <= ST_FLUSH;
							end
							cube_q <= cube_next;
						end
					end else if (hit && par_fixed) begin
						// a parent is an implicant, so this cube was merged
						step_q <= '0;
						if (cube_is_last) begin
							state_q <= ST_FLUSH;
						end
						cube_q <= cube_next;
					end else if (step_q == nv) begin
						// no parent is an implicant: prime found, hold it
						step_q       <= '0;
						pend_valid_q <= 1'b1;
						count_q      <= CNT_W'(count_q + 1'b1);
						if (cube_is_last || int'(count_q) + 1 == MAX_RESULTS) begin
							state_q <= ST_FLUSH;
						end
						cube_q <= cube_next;
					end else begin
						step_q <= NV_W'(step_q + 1'b1);
					end
				end
				ST_FLUSH: begin
					pend_valid_q <= 1'b0;
					bitmap_q     <= '0;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && step_q != '0 && !(hit && par_fixed) && step_q == nv) begin
			pend_value_q <= cube_val;
			pend_dash_q  <= cube_dash;
		end
		if (emit) begin
			pi_value_q     <= emit_value_w[PI_W-1:0];
			pi_dash_mask_q <= emit_dash_w[PI_W-1:0];
			pi_last_q      <= emit_last;
		end
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for prime_implicant_generator, a directed table then random functions
// depends on pig_pkg and prime_implicant_generator; answers are checked by a predictor or a typed row
module tb_top
	import pig_pkg::*;
();

	// one prime implicant as it leaves the block
	typedef struct packed {
		logic [PI_W-1:0] value;
		logic [PI_W-1:0] dash;
		logic            last;
	} implicant_t;

	// one row of the directed table: optional num_vars write, then one item,
	// and where the answer is obvious a single typed implicant
	typedef struct packed {
		logic                 wr_cfg;
		logic [CFG_W-1:0]     cfg;
		logic [MINTERM_W-1:0] m;
		logic                 fin;
		logic                 typed;
		logic [PI_W-1:0]      t_value;
		logic [PI_W-1:0]      t_dash;
	} stim_row_t;

	localparam int N_ROWS = 23;
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		// reset value of num_vars, lone minterms at both extremes
		'{1'b0, 3'd0, 4'd0,  1'b1, 1'b1, 4'd0,  4'd0},
		'{1'b0, 3'd0, 4'd15, 1'b1, 1'b1, 4'd15, 4'd0},
		// two variables, full cover collapses to one all-dash cube
		'{1'b1, 3'd2, 4'd0,  1'b0, 1'b0, 4'd0,  4'd0},
		'{1'b0, 3'd0, 4'd1,  1'b0, 1'b0, 4'd0,  4'd0},
		'{1'b0, 3'd0, 4'd2,  1'b0, 1'b0, 4'd0,  4'd0},
		'{1'b0, 3'd0, 4'd3,  1'b1, 1'b1, 4'd0,  4'd3},
		// one variable, both minterms
		'{1'b1, 3'd1, 4'd0,  1'b0, 1'b0, 4'd0,  4'd0},
		'{1'b0, 3'd0, 4'd1,  1'b1, 1'b1, 4'd0,  4'd1},
		// zero variables acts as one, upper bits masked away
		'{1'b1, 3'd0, 4'd14, 1'b1, 1'b1, 4'd0,  4'd0},
		// count above the build size acts as four; two isolated minterms
		'{1'b1, 3'd7, 4'd10, 1'b0, 1'b0, 4'd0,  4'd0},
		'{1'b0, 3'd0, 4'd5,  1'b1, 1'b0, 4'd0,  4'd0},
		// textbook four-variable function with two quad implicants
		'{1'b1, 3'd4, 4'd0,  1'b0, 1'b0, 4'd0,  4'd0},
		'{1'b0, 3'd0, 4'd2,  1'b0, 1'b0, 4'd0,  4'd0},
		'{1'b0, 3'd0, 4'd5,  1'b0, 1'b0, 4'd0,  4'd0},
		'{1'b0, 3'd0, 4'd7,  1'b0, 1'b0, 4'd0,  4'd0},
		'{1'b0, 3'd0, 4'd8,  1'b0, 1'b0, 4'd0,  4'd0},
		'{1'b0, 3'd0, 4'd10, 1'b0, 1'b0, 4'd0,  4'd0},
		'{1'b0, 3'd0, 4'd13, 1'b0, 1'b0, 4'd0,  4'd0},
		'{1'b0, 3'd0, 4'd15, 1'b1, 1'b0, 4'd0,  4'd0},
		// count shrunk mid-function: earlier high minterms are ignored
		'{1'b0, 3'd0, 4'd15, 1'b0, 1'b0, 4'd0,  4'd0},
		'{1'b0, 3'd0, 4'd6,  1'b0, 1'b0, 4'd0,  4'd0},
		'{1'b1, 3'd2, 4'd1,  1'b1, 1'b1, 4'd1,  4'd0},
		// three variables
		'{1'b1, 3'd3, 4'd7,  1'b1, 1'b1, 4'd7,  4'd0}
	};

	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic [MINTERM_W-1:0] minterm    = '0;
	logic                 final_term = 1'b0;
	logic                 cfg_valid  = 1'b0;
	logic [CFG_W-1:0]     cfg_data   = '0;
	logic                 busy;
	logic                 cfg_ready;
	logic                 pi_valid;
	logic [PI_W-1:0]      pi_value;
	logic [PI_W-1:0]      pi_dash_mask;
	logic                 pi_last;

	// bench copy of the block state
	logic [(1<<VARS_DEFAULT)-1:0] seen_minterms = '0;
	logic [CFG_W-1:0]             num_vars_reg  = NUM_VARS_RESET;
	implicant_t                   pending_implicants [$];
	int                           mismatches = 0;
	int                           gap_pct    = 0;

	prime_implicant_generator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.minterm      (minterm),
		.final_term   (final_term),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.pi_valid     (pi_valid),
		.pi_value     (pi_value),
		.pi_dash_mask (pi_dash_mask),
		.pi_last      (pi_last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("prime_implicant_generator: mismatch");
		$finish;
	end

	// out-of-range counts clamp to 1..VARS
	function automatic int vars_active();
		int n;
		n = int'(num_vars_reg);
		if (n < 1) n = 1;
		if (n > VARS_DEFAULT) n = VARS_DEFAULT;
		return n;
	endfunction

	function automatic int pow3(input int b);
		int p;
		p = 1;
		repeat (b) p = p * 3;
		return p;
	endfunction

	// cube index is base 3, variable b at weight 3^b
	function automatic digit_t cube_digit(input int c, input int b);
		return digit_t'((c / pow3(b)) % 3);
	endfunction

	// appends one implicant to the tail of the expected queue
	function automatic void queue_expected(input implicant_t imp);
		pending_implicants.insert(pending_implicants.size(), imp);
	endfunction

	// records the minterm; on a final item runs the tabulation and queues the primes
	function automatic void predict_item(input logic [MINTERM_W-1:0] m_in, input logic fin,
		input bit keep);
		int         nv, cubes, idx, partner, dashes, c, b, k, m;
		bit         present [81];
		bit         merged [81];
		implicant_t found [$];
		implicant_t imp;
		nv = vars_active();
		seen_minterms[int'(m_in) & ((1 << nv) - 1)] = 1'b1;
		if (!fin)
			return;
		cubes = pow3(nv);
		for (c = 0; c < 81; c++) begin
			present[c] = 1'b0;
			merged[c]  = 1'b0;
		end
		// indices at or above 2^nv stay in the bitmap but take no part
		for (m = 0; m < (1 << nv); m++) begin
			if (!seen_minterms[m])
				continue;
			idx = 0;
			for (b = 0; b < nv; b++)
				idx += (((m >> b) & 1) ? int'(DIG_ONE) : int'(DIG_ZERO)) * pow3(b);
			present[idx] = 1'b1;
		end
		// merge level by level, level being the number of dashes
		for (k = 0; k < nv; k++) begin
			for (c = 0; c < cubes; c++) begin
				if (!present[c])
					continue;
				dashes = 0;
				for (b = 0; b < nv; b++)
					if (cube_digit(c, b) == DIG_DASH) dashes++;
				if (dashes != k)
					continue;
				for (b = 0; b < nv; b++) begin
					if (cube_digit(c, b) != DIG_ZERO)
						continue;
					partner = c + pow3(b);
					if (!present[partner])
						continue;
					merged[c]       = 1'b1;
					merged[partner] = 1'b1;
					present[c - pow3(b)] = 1'b1;
				end
			end
		end
		// unmerged cubes of every level, ascending, capped
		for (c = 0; c < cubes && found.size() < MAX_RESULTS; c++) begin
			if (!present[c] || merged[c])
				continue;
			imp = '0;
			for (b = 0; b < nv; b++) begin
				if (cube_digit(c, b) == DIG_DASH) imp.dash[b] = 1'b1;
				else if (cube_digit(c, b) == DIG_ONE) imp.value[b] = 1'b1;
			end
			found.insert(found.size(), imp);
		end
		if (found.size() > 0)
			found[found.size()-1].last = 1'b1;
		if (keep)
			foreach (found[i]) queue_expected(found[i]);
		seen_minterms = '0;
	endfunction

	task automatic log_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// one item; start is held through busy and only dropped for a random gap
	task automatic send_item(input logic [MINTERM_W-1:0] m, input logic fin, input bit keep);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		minterm    <= m;
		final_term <= fin;
		do @(posedge clk); while (busy);
		predict_item(m, fin, keep);
	endtask

	// wait for every queued implicant, then let the scan finish
	task automatic drain_results();
		while (pending_implicants.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_num_vars(input logic [CFG_W-1:0] v);
		start <= 1'b0;
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		num_vars_reg = v;
		cfg_valid <= 1'b0;
	endtask

	// results cannot be held off, so every strobe is consumed here
	always @(posedge clk) begin
		implicant_t want;
		if (arst_n && pi_valid) begin
			if (pending_implicants.size() == 0) begin
				log_mismatch("implicant with nothing expected", int'(pi_value), -1);
			end else begin
				want = pending_implicants.pop_front();
				if (pi_value !== want.value)
					log_mismatch("pi_value", int'(pi_value), int'(want.value));
				if (pi_dash_mask !== want.dash)
					log_mismatch("pi_dash_mask", int'(pi_dash_mask), int'(want.dash));
				if (pi_last !== want.last)
					log_mismatch("pi_last", int'(pi_last), int'(want.last));
			end
		end
	end

	initial begin
		stim_row_t row;
		int        sent, len, j;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, light sender gaps
		gap_pct = 8;
		for (int i = 0; i < N_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.wr_cfg)
				write_num_vars(row.cfg);
			send_item(row.m, row.fin, !row.typed);
			if (row.typed)
				queue_expected(implicant_t'{row.t_value, row.t_dash, 1'b1});
		end

		// random functions: light gaps, heavy gaps, then back to back
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = (ph == 0) ? 8 : (ph == 1) ? 74 : 0;
			sent = 0;
			while (sent < 33) begin
				if ($urandom_range(99) < 30)
					write_num_vars(CFG_W'($urandom_range(0, 7)));
				len = $urandom_range(1, 10);
				for (j = 0; j < len; j++) begin
					// occasional count change part way through a function
					if (j > 0 && $urandom_range(99) < 5)
						write_num_vars(CFG_W'($urandom_range(0, 7)));
					send_item(MINTERM_W'($urandom_range(0, 15)), j == len - 1, 1'b1);
				end
				sent += len;
			end
			// sender holds off until the whole answer is out
			start <= 1'b0;
			drain_results();
		end

		while (pending_implicants.size() != 0) @(posedge clk);
		repeat (450) @(posedge clk);
		if (mismatches == 0)
			$display("prime_implicant_generator: match");
		else
			$display("prime_implicant_generator: mismatch");
		$finish;
	end

endmodule
